>>> src/ssrq_pkg.sv
// ssrq_pkg: types, codes and helpers of the slot state ring queue
// no dependencies, used by every module of the block
`timescale 1ns / 1ps

package ssrq_pkg;

  localparam int MaxSlots = 16;
  localparam int SlotIdxW = $clog2(MaxSlots);
  localparam int RingW    = $clog2(MaxSlots + 1);

  typedef enum logic [1:0] {
    ST_EMPTY      = 2'd0,
    ST_ALLOCATED  = 2'd1,
    ST_FULL       = 2'd2,
    ST_PROCESSING = 2'd3
  } slot_status_e;

  typedef enum logic [3:0] {
    FN_INSERT   = 4'd0,
    FN_ALLOCATE = 4'd1,
    FN_FINALIZE = 4'd2,
    FN_READ     = 4'd3,
    FN_PROCESS  = 4'd4,
    FN_DONE     = 4'd5,
    FN_ABORT    = 4'd6,
    FN_FULLQ    = 4'd7,
    FN_RESET    = 4'd8
  } func_e;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_SLOTS    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    slot_status_e status;
    logic [15:0]  length;
    logic [31:0]  ident;
    logic         abort;
  } slot_entry_t;

  typedef struct packed {
    logic                en;
    logic                clr;
    logic [SlotIdxW-1:0] addr;
    slot_entry_t         data;
  } slot_wr_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] data_length;
    logic [3:0]  slot_ref;
    logic [31:0] abort_id;
    logic [15:0] copy_limit;
  } cmd_t;

  typedef struct packed {
    logic        success;
    logic [3:0]  slot_index;
    logic [15:0] entry_length;
    logic [31:0] entry_id;
    logic [15:0] copy_length;
    logic        entry_aborted;
    logic        queue_full;
    logic        overrun_flag;
    logic [31:0] overrun_total;
  } res_t;

  // zero acts as one, values above the slot count act as the slot count
  function automatic logic [RingW-1:0] ring_len(input logic [4:0] slots);
    logic [RingW-1:0] r;
    if (slots == 5'd0) begin
      r = RingW'(1);
    end else if (32'(slots) > 32'(MaxSlots)) begin
      r = RingW'(MaxSlots);
    end else begin
      r = RingW'(slots);
    end
    return r;
  endfunction

  function automatic logic [SlotIdxW-1:0] advance(input logic [SlotIdxW-1:0] p,
                                                  input logic [RingW-1:0] rl);
    logic [RingW:0] n;
    n = (RingW + 1)'(p) + (RingW + 1)'(1);
    return (n >= (RingW + 1)'(rl)) ? '0 : n[SlotIdxW-1:0];
  endfunction

endpackage

>>> src/slot_state_ring_queue_unit.sv
// Slot state ring queue: one command word in, one result word out. A command
// reads slots of the slot store one at a time and writes back those it changes;
// a skip of aborted slots clears each slot dropped, and an abort scan visits
// every ring slot in turn. The result sits in an output register so the next
// command can be taken while it waits. Config writes belong only in gaps
// with no command in flight. Depends on ssrq_pkg, ssrq_slot_mem and ssrq_ctrl.
`timescale 1ns / 1ps

module slot_state_ring_queue_unit
  import ssrq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_length[15:0], slot_ref[19:16], abort_id[51:20], copy_limit[67:52]
  input  logic [71:0]  s_tdata,
  // func[3:0]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // success[0], slot_index[4:1], entry_length[20:5], entry_id[52:21],
  // copy_length[68:53], entry_aborted[69], queue_full[70], overrun_flag[71],
  // overrun_total[103:72]
  output logic [103:0] m_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0] capacity_q;
  logic [4:0] slots_q;
  logic busy, res_valid, res_ready, clr_all;
  cmd_t cmd;
  res_t res;
  slot_wr_t wr;
  logic [SlotIdxW-1:0] raddr;
  slot_entry_t rdata;
  logic out_valid_q;
  logic [103:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 16'd256;
      slots_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAPACITY: capacity_q <= cfg_data_i;
        CFG_SLOTS: slots_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !busy;
  assign cmd.func = s_tuser;
  assign cmd.data_length = s_tdata[15:0];
  assign cmd.slot_ref = s_tdata[19:16];
  assign cmd.abort_id = s_tdata[51:20];
  assign cmd.copy_limit = s_tdata[67:52];

  ssrq_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_all_i (clr_all),
    .wr_i      (wr),
    .raddr_i   (raddr),
    .rdata_o   (rdata)
  );

  ssrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_tvalid && s_tready),
    .cmd_i       (cmd),
    .capacity_i  (capacity_q),
    .slots_i     (slots_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .clr_all_o   (clr_all),
    .wr_o        (wr),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  assign res_ready = !out_valid_q || m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {res.overrun_total, res.overrun_flag, res.queue_full,
                     res.entry_aborted, res.copy_length, res.entry_id,
                     res.entry_length, res.slot_index, res.success};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata = out_data_q;

endmodule

>>> src/ssrq_slot_mem.sv
// ssrq_slot_mem: slot store, one write and one registered read port
// per-entry valid bits give the cleared entry; depends on ssrq_pkg
`timescale 1ns / 1ps

module ssrq_slot_mem
  import ssrq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_all_i,
  input  slot_wr_t            wr_i,
  input  logic [SlotIdxW-1:0] raddr_i,
  output slot_entry_t         rdata_o
);

  slot_entry_t mem_q [MaxSlots];
  logic [MaxSlots-1:0] valid_q;
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_all_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= !wr_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.clr) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // write-first forwarding when the same entry is read and written
  always_ff @(posedge clk_i) begin
    if (clr_all_i) begin
      rdata_q <= '0;
    end else if (wr_i.en && wr_i.addr == raddr_i) begin
      rdata_q <= wr_i.clr ? '0 : wr_i.data;
    end else begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ssrq_ctrl.sv
// ssrq_ctrl: command sequencer with ring pointers and counters
// reads, modifies and writes back the slot store; depends on ssrq_pkg
`timescale 1ns / 1ps

module ssrq_ctrl
  import ssrq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cmd_t                cmd_i,
  input  logic [15:0]         capacity_i,
  input  logic [4:0]          slots_i,
  output logic                busy_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o,
  output logic                clr_all_o,
  output slot_wr_t            wr_o,
  output logic [SlotIdxW-1:0] raddr_o,
  input  slot_entry_t         rdata_i
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DISP    = 10'b00_0000_0010,
    S_SKIP_RD = 10'b00_0000_0100,
    S_SKIP_EV = 10'b00_0000_1000,
    S_CMD_RD  = 10'b00_0001_0000,
    S_CMD_EV  = 10'b00_0010_0000,
    S_SCAN_RD = 10'b00_0100_0000,
    S_SCAN_EV = 10'b00_1000_0000,
    S_STAT_RD = 10'b01_0000_0000,
    S_STAT_EV = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic [SlotIdxW-1:0] wp_q, wp_d, fp_q, fp_d, rp_q, rp_d, pp_q, pp_d, p_q, p_d;
  logic ovf_q, ovf_d;
  logic [31:0] ovc_q, ovc_d, nid_q, nid_d;
  logic post_q, post_d;
  logic [RingW-1:0] scan_q, scan_d;
  logic ok_q, ok_d, eab_q, eab_d;
  logic [SlotIdxW-1:0] idx_q, idx_d;
  logic [15:0] elen_q, elen_d;
  logic [31:0] eid_q, eid_d;

  logic [RingW-1:0] rl;
  logic [SlotIdxW-1:0] nxt;
  func_e fn;

  assign rl = ring_len(slots_i);
  assign fn = func_e'(cmd_q.func);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    wp_d = wp_q; fp_d = fp_q; rp_d = rp_q; pp_d = pp_q; p_d = p_q;
    ovf_d = ovf_q; ovc_d = ovc_q; nid_d = nid_q;
    post_d = post_q; scan_d = scan_q;
    ok_d = ok_q; eab_d = eab_q; idx_d = idx_q; elen_d = elen_q; eid_d = eid_q;
    clr_all_o = 1'b0;
    wr_o = '0;
    raddr_o = wp_q;
    res_valid_o = 1'b0;
    nxt = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        ok_d = 1'b0; eab_d = 1'b0; idx_d = '0; elen_d = '0; eid_d = '0;
        post_d = 1'b0;
        scan_d = '0;
        case (fn)
          FN_READ, FN_PROCESS: state_d = S_SKIP_RD;
          FN_FULLQ: begin
            ok_d = 1'b1;
            state_d = S_SKIP_RD;
          end
          FN_INSERT, FN_ALLOCATE, FN_FINALIZE, FN_DONE: state_d = S_CMD_RD;
          FN_ABORT: state_d = S_SCAN_RD;
          FN_RESET: begin
            clr_all_o = 1'b1;
            wp_d = '0; fp_d = '0; rp_d = '0; pp_d = '0;
            ovf_d = 1'b0; ovc_d = '0; nid_d = 32'd1;
            ok_d = 1'b1;
            state_d = S_STAT_RD;
          end
          default: state_d = S_STAT_RD;
        endcase
      end
      S_SKIP_RD: begin
        raddr_o = rp_q;
        state_d = S_SKIP_EV;
      end
      S_SKIP_EV: begin
        if (rdata_i.abort) begin
          // drop an aborted slot sitting at the read pointer
          wr_o.en = 1'b1; wr_o.clr = 1'b1; wr_o.addr = rp_q;
          nxt = advance(rp_q, rl);
          rp_d = nxt;
          pp_d = nxt;
          state_d = S_SKIP_RD;
        end else if (post_q || fn == FN_FULLQ) begin
          state_d = S_STAT_RD;
        end else begin
          state_d = S_CMD_RD;
        end
      end
      S_CMD_RD: begin
        case (fn)
          FN_FINALIZE: raddr_o = fp_q;
          FN_READ, FN_PROCESS: raddr_o = rp_q;
          FN_DONE: raddr_o = pp_q;
          default: raddr_o = wp_q;
        endcase
        p_d = raddr_o;
        state_d = S_CMD_EV;
      end
      S_CMD_EV: begin
        nxt = advance(p_q, rl);
        state_d = S_STAT_RD;
        wr_o.addr = p_q;
        wr_o.data = rdata_i;
        case (fn)
          FN_INSERT: begin
            if (rdata_i.status == ST_EMPTY && cmd_q.data_length <= capacity_i &&
                fp_q == wp_q) begin
              wr_o.en = 1'b1;
              wr_o.data.status = ST_FULL;
              wr_o.data.length = cmd_q.data_length;
              wr_o.data.ident = nid_q;
              ok_d = 1'b1; idx_d = p_q; elen_d = cmd_q.data_length; eid_d = nid_q;
              nid_d = nid_q + 32'd1;
              wp_d = nxt; fp_d = nxt;
            end
          end
          FN_ALLOCATE: begin
            if (rdata_i.status != ST_EMPTY) begin
              ovf_d = 1'b1;
              ovc_d = ovc_q + 32'd1;
            end else if (fp_q == wp_q) begin
              wr_o.en = 1'b1;
              wr_o.data.status = ST_ALLOCATED;
              wr_o.data.ident = nid_q;
              ok_d = 1'b1; idx_d = p_q; elen_d = rdata_i.length; eid_d = nid_q;
              nid_d = nid_q + 32'd1;
              fp_d = p_q; wp_d = nxt;
            end
          end
          FN_FINALIZE: begin
            if (rdata_i.status == ST_ALLOCATED && 32'(cmd_q.slot_ref) == 32'(p_q)) begin
              wr_o.en = 1'b1;
              wr_o.data.status = ST_FULL;
              wr_o.data.length = cmd_q.data_length;
              ok_d = 1'b1; idx_d = p_q; elen_d = cmd_q.data_length;
              eid_d = rdata_i.ident;
              fp_d = nxt;
            end
          end
          FN_READ: begin
            if (rdata_i.status == ST_FULL && rp_q == pp_q) begin
              wr_o.en = 1'b1; wr_o.clr = 1'b1;
              ok_d = 1'b1; idx_d = p_q; elen_d = rdata_i.length; eid_d = rdata_i.ident;
              rp_d = nxt; pp_d = nxt;
              post_d = 1'b1;
              state_d = S_SKIP_RD;
            end
          end
          FN_PROCESS: begin
            if (rdata_i.status == ST_FULL && pp_q == rp_q) begin
              wr_o.en = 1'b1;
              wr_o.data.status = ST_PROCESSING;
              ok_d = 1'b1; idx_d = p_q; elen_d = rdata_i.length; eid_d = rdata_i.ident;
              pp_d = p_q; rp_d = nxt;
            end
          end
          FN_DONE: begin
            if (rdata_i.status == ST_PROCESSING) begin
              wr_o.en = 1'b1; wr_o.clr = 1'b1;
              ok_d = 1'b1; idx_d = p_q; elen_d = rdata_i.length; eid_d = rdata_i.ident;
              eab_d = rdata_i.abort;
              pp_d = nxt;
              post_d = 1'b1;
              state_d = S_SKIP_RD;
            end
          end
          default: ;
        endcase
      end
      S_SCAN_RD: begin
        raddr_o = scan_q[SlotIdxW-1:0];
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (rdata_i.status != ST_EMPTY && rdata_i.ident == cmd_q.abort_id) begin
          wr_o.en = 1'b1;
          wr_o.addr = scan_q[SlotIdxW-1:0];
          wr_o.data = rdata_i;
          wr_o.data.abort = 1'b1;
          ok_d = 1'b1; idx_d = scan_q[SlotIdxW-1:0]; elen_d = rdata_i.length;
          eid_d = cmd_q.abort_id;
        end
        scan_d = scan_q + RingW'(1);
        state_d = (scan_d >= rl) ? S_STAT_RD : S_SCAN_RD;
      end
      S_STAT_RD: begin
        raddr_o = wp_q;
        state_d = S_STAT_EV;
      end
      S_STAT_EV: begin
        raddr_o = wp_q;
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o.success = ok_q;
    res_o.slot_index = 4'(idx_q);
    res_o.entry_length = elen_q;
    res_o.entry_id = eid_q;
    res_o.copy_length = !ok_q ? 16'd0 :
                        (elen_q < cmd_q.copy_limit) ? elen_q : cmd_q.copy_limit;
    res_o.entry_aborted = eab_q;
    res_o.queue_full = (rdata_i.status != ST_EMPTY);
    res_o.overrun_flag = ovf_q;
    res_o.overrun_total = ovc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q <= '0; fp_q <= '0; rp_q <= '0; pp_q <= '0;
      ovf_q <= 1'b0; ovc_q <= '0; nid_q <= 32'd1;
      post_q <= 1'b0; scan_q <= '0;
    end else begin
      state_q <= state_d;
      wp_q <= wp_d; fp_q <= fp_d; rp_q <= rp_d; pp_q <= pp_d;
      ovf_q <= ovf_d; ovc_q <= ovc_d; nid_q <= nid_d;
      post_q <= post_d; scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    p_q <= p_d;
    ok_q <= ok_d; eab_q <= eab_d; idx_q <= idx_d; elen_q <= elen_d; eid_q <= eid_d;
  end

endmodule
